// File: rtl/core/icmp_pkg.sv
`timescale 1ns / 1ps

package icmp_pkg;

   localparam int MAX_PACKET_BYTES = 512;
   localparam int WORD_BYTES       = 8;
   localparam int STORE_DEPTH      = (MAX_PACKET_BYTES + WORD_BYTES - 1) / WORD_BYTES;
   localparam int ADDR_W           = $clog2(STORE_DEPTH);
   localparam int BYTE_SHIFT       = $clog2(WORD_BYTES);
   localparam int LEN_W            = $clog2(MAX_PACKET_BYTES + 1);
   localparam int CNT_W            = 4;
   localparam int WORD_W           = 64;
   localparam int LIMIT_W          = 10;
   localparam int LANES            = WORD_BYTES / 2;

   localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'd8;
   localparam logic [15:0] OC_ZERO           = 16'hffff;

   localparam logic [2:0] STATUS_REPLY     = 3'd0;
   localparam logic [2:0] STATUS_SHORT     = 3'd1;
   localparam logic [2:0] STATUS_NOT_ECHO  = 3'd2;
   localparam logic [2:0] STATUS_BAD_SUM   = 3'd3;
   localparam logic [2:0] STATUS_NO_ROOM   = 3'd4;
   localparam logic [2:0] STATUS_BAD_LEN   = 3'd5;

   typedef struct packed {
      logic [WORD_W-1:0] packet_word;
      logic [CNT_W-1:0]  byte_count;
      logic              last;
      logic [31:0]       source_address;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] reply_word;
      logic [CNT_W-1:0]  reply_bytes;
      logic              reply_last;
      logic [31:0]       dest_address;
      logic [2:0]        status;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_CHECK,
      ST_SEND
   } state_type;

   // Bit i is set when byte i (byte 0 in the top bits) is among the first count bytes.
   function automatic logic [WORD_BYTES-1:0] byte_mask(input logic [CNT_W-1:0] count);
      logic [WORD_BYTES-1:0] mask;
      for (int i = 0; i < WORD_BYTES; i++) begin
         mask[i] = CNT_W'(i) < count;
      end
      return mask;
   endfunction

   // Ones'-complement addition with end-around carry.
   function automatic logic [15:0] eac_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[15:0] + {15'b0, t[16]};
   endfunction

endpackage

// File: rtl/core/icmp_ram.sv
`timescale 1ns / 1ps

module icmp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/icmp_lane.sv
`timescale 1ns / 1ps

module icmp_lane import icmp_pkg::*; (
   input  logic [15:0] half_word,
   input  logic [1:0]  byte_valid,
   output logic [15:0] lane_value
);

   // The upper byte of a lane sits at an even packet offset and carries the high weight.
   always_comb begin
      lane_value[15:8] = byte_valid[1] ? half_word[15:8] : 8'h00;
      lane_value[7:0]  = byte_valid[0] ? half_word[7:0]  : 8'h00;
   end

endmodule

// File: rtl/core/icmp_merge.sv
`timescale 1ns / 1ps

module icmp_merge import icmp_pkg::*; (
   input  logic [LANES-1:0][15:0] lane_value,
   input  logic [15:0]            sum_now,
   output logic [15:0]            sum_next
);

   // The running sum never drops to zero, so the result stays canonical
   // with 0xffff standing for the ones'-complement zero.
   always_comb begin
      logic [15:0] acc;
      acc = sum_now;
      for (int l = 0; l < LANES; l++) begin
         acc = eac_add(acc, lane_value[l]);
      end
      sum_next = acc;
   end

endmodule

// File: rtl/core/icmp_echo_responder.sv
`timescale 1ns / 1ps

// ICMP echo responder. Packet words are taken one per cycle while busy is low,
// each with its valid byte count; the word marked last closes the packet. The
// message is written to a 64-word packet memory while four 16-bit lanes sum it.
// After the last word the block runs its checks in the check state, then either
// strobes one status result or streams the echo reply as ceil(len/8) words, one
// per cycle, paced by the single read port of the packet memory. Busy stays high
// until the status result or the last reply word is formed, so the next packet
// waits for it. Results are registered and are valid only while rsp_strobe is
// high; the receiver cannot stall them, so it must take a word on every strobe.
// The memory needs no clearing: only bytes of the current packet are ever read.
// reply_limit is to be written through csr_wr_en/csr_wr_data only while the
// block is idle; the block itself does not enforce this.

module icmp_echo_responder import icmp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_strobe,
   output rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

   state_type          state_ff, state_in;
   logic [LEN_W-1:0]   rcv_ff, rcv_in;
   logic [15:0]        sum_ff, sum_in;
   logic               too_long_ff, too_long_in;
   logic [31:0]        head_ff, head_in;
   logic [31:0]        src_ff, src_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic [15:0]        ck_ff, ck_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic               first_ff, first_in;
   logic [ADDR_W-1:0]  rd_addr_ff, rd_addr_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic [CNT_W-1:0]   cnt_c;
   logic [LEN_W:0]     bytes_after;
   logic               overflow;
   logic               short_mid;
   logic               store;
   logic [CNT_W-1:0]   send_bytes;
   logic               send_last;
   logic [2:0]         check_status;
   logic [15:0]        head_sum;

   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [WORD_W-1:0]     ram_rd_data;

   logic [WORD_W-1:0]        lane_src;
   logic [WORD_BYTES-1:0]    lane_mask;
   logic [LANES-1:0][15:0]   lane_value;
   logic [WORD_W-1:0]        masked_word;
   logic [15:0]              sum_next;

   assign busy   = state_ff != ST_COLLECT;
   assign accept = start && !busy;

   assign cnt_c       = (req_data.byte_count > CNT_W'(WORD_BYTES)) ?
                        CNT_W'(WORD_BYTES) : req_data.byte_count;
   assign bytes_after = {1'b0, rcv_ff} + (LEN_W + 1)'(cnt_c);
   assign overflow    = bytes_after > (LEN_W + 1)'(MAX_PACKET_BYTES);
   assign short_mid   = !req_data.last && (cnt_c != CNT_W'(WORD_BYTES));
   assign store       = accept && !too_long_ff && !short_mid && !overflow &&
                        (cnt_c != '0);
   assign ram_wr_en   = store;

   assign send_bytes = (rem_ff > LEN_W'(WORD_BYTES)) ? CNT_W'(WORD_BYTES) :
                       rem_ff[CNT_W-1:0];
   assign send_last  = rem_ff <= LEN_W'(WORD_BYTES);

   // The lanes mask the incoming word while collecting and the reply word while sending.
   assign lane_src  = (state_ff == ST_COLLECT) ? req_data.packet_word : ram_rd_data;
   assign lane_mask = (state_ff == ST_COLLECT) ? byte_mask(cnt_c) : byte_mask(send_bytes);

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      icmp_lane u_lane (
         .half_word  (lane_src[WORD_W-1-16*l -: 16]),
         .byte_valid ({lane_mask[2*l], lane_mask[2*l+1]}),
         .lane_value (lane_value[l])
      );
      assign masked_word[WORD_W-1-16*l -: 16] = lane_value[l];
   end

   icmp_merge u_merge (
      .lane_value (lane_value),
      .sum_now    (sum_ff),
      .sum_next   (sum_next)
   );

   icmp_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (rcv_ff[ADDR_W+BYTE_SHIFT-1:BYTE_SHIFT]),
      .wr_data (req_data.packet_word),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // With a verified packet the sum over bytes four onward is the negation of
   // the sum of the first four bytes, so the new checksum follows from the header.
   assign head_sum = eac_add(head_ff[31:16], head_ff[15:0]);

   always_comb begin
      if (too_long_ff) begin
         check_status = STATUS_BAD_LEN;
      end else if (rcv_ff < LEN_W'(4)) begin
         check_status = STATUS_SHORT;
      end else if (head_ff[31:24] != ICMP_ECHO_REQUEST) begin
         check_status = STATUS_NOT_ECHO;
      end else if (rcv_ff < LEN_W'(8)) begin
         check_status = STATUS_SHORT;
      end else if (rcv_ff[0]) begin
         check_status = STATUS_BAD_LEN;
      end else if (sum_ff != OC_ZERO) begin
         check_status = STATUS_BAD_SUM;
      end else if (limit_ff == '0 || LEN_W'(limit_ff) < rcv_ff) begin
         check_status = STATUS_NO_ROOM;
      end else begin
         check_status = STATUS_REPLY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_COLLECT;
         rcv_ff        <= '0;
         sum_ff        <= OC_ZERO;
         too_long_ff   <= 1'b0;
         limit_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rcv_ff        <= rcv_in;
         sum_ff        <= sum_in;
         too_long_ff   <= too_long_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      head_ff    <= head_in;
      src_ff     <= src_in;
      ck_ff      <= ck_in;
      rem_ff     <= rem_in;
      first_ff   <= first_in;
      rd_addr_ff <= rd_addr_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      rcv_in        = rcv_ff;
      sum_in        = sum_ff;
      too_long_in   = too_long_ff;
      head_in       = head_ff;
      src_in        = src_ff;
      ck_in         = ck_ff;
      rem_in        = rem_ff;
      first_in      = first_ff;
      rd_addr_in    = rd_addr_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = rd_addr_ff;

      case (state_ff)
         ST_COLLECT: begin
            if (accept) begin
               too_long_in = too_long_ff || short_mid || overflow;
               if (store) begin
                  rcv_in = bytes_after[LEN_W-1:0];
                  sum_in = sum_next;
                  if (rcv_ff == '0) begin
                     head_in = req_data.packet_word[WORD_W-1 -: 32];
                  end
               end
               if (req_data.last) begin
                  src_in   = req_data.source_address;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            ck_in       = (head_sum == OC_ZERO) ? 16'h0000 : head_sum;
            rem_in      = rcv_ff;
            first_in    = 1'b1;
            rcv_in      = '0;
            sum_in      = OC_ZERO;
            too_long_in = 1'b0;
            if (check_status != STATUS_REPLY) begin
               rsp_strobe_in       = 1'b1;
               rsp_in.reply_word   = '0;
               rsp_in.reply_bytes  = '0;
               rsp_in.reply_last   = 1'b1;
               rsp_in.dest_address = '0;
               rsp_in.status       = check_status;
               state_in            = ST_COLLECT;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
               rd_addr_in  = ADDR_W'(1);
               state_in    = ST_SEND;
            end
         end
         ST_SEND: begin
            rsp_strobe_in       = 1'b1;
            rsp_in.reply_word   = masked_word;
            if (first_ff) begin
               rsp_in.reply_word[WORD_W-1 -: 32] = {16'h0000, ck_ff};
            end
            rsp_in.reply_bytes  = send_bytes;
            rsp_in.reply_last   = send_last;
            rsp_in.dest_address = src_ff;
            rsp_in.status       = STATUS_REPLY;
            ram_rd_en           = 1'b1;
            rd_addr_in          = rd_addr_ff + ADDR_W'(1);
            rem_in              = rem_ff - LEN_W'(WORD_BYTES);
            first_in            = 1'b0;
            if (send_last) begin
               state_in = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// File: rtl/core/icmp_chk.sv
`timescale 1ns / 1ps

module icmp_chk import icmp_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input req_type            req_data,
   input logic               rsp_strobe,
   input rsp_type            rsp_data
);

   // A status result is a single empty word.
   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != STATUS_REPLY |->
         rsp_data.reply_last && rsp_data.reply_bytes == '0 && rsp_data.reply_word == '0)
      else $error("status result is not a single empty word");

   // A reply word always carries data.
   a_reply_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == STATUS_REPLY |-> rsp_data.reply_bytes != '0)
      else $error("reply word without bytes");

   // Reply words of one packet come back to back.
   a_reply_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.reply_last |=> rsp_strobe)
      else $error("gap inside a reply burst");

   // No new word is taken while a reply is still streaming.
   a_busy_in_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.reply_last |-> busy)
      else $error("block idle in the middle of a reply");

   // A word that does not close its packet produces no result.
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_data.last |=> !rsp_strobe)
      else $error("result after a word that is not last");

endmodule

bind icmp_echo_responder icmp_chk u_icmp_chk (.*);

// File: tb/icmp_echo_checker.sv
`timescale 1ns / 1ps

module icmp_echo_checker import icmp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  req_type            req_data,
   input  logic               rsp_strobe,
   input  rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data,
   output int                 error_count,
   output int                 words_pending
);

   logic [WORD_W-1:0]  msg_mem [STORE_DEPTH];
   int unsigned        msg_len;
   logic [15:0]        msg_sum;
   logic               msg_broken;
   logic [LIMIT_W-1:0] reply_limit;
   rsp_type            reply_queue [$];

   function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] v);
      logic [16:0] t;
      t = {1'b0, acc} + {1'b0, v};
      if (t > 17'h0ffff) begin
         t = t - 17'h0ffff;
      end
      return t[15:0];
   endfunction

   // Even byte positions are the high half of a 16-bit word in network order.
   function automatic logic [15:0] weighted(input int unsigned pos, input logic [7:0] b);
      return pos[0] ? {8'h00, b} : {b, 8'h00};
   endfunction

   function automatic logic [7:0] msg_byte(input int unsigned pos);
      return msg_mem[pos / WORD_BYTES][WORD_W-1-8*(pos % WORD_BYTES) -: 8];
   endfunction

   task automatic clear_message();
      msg_len    = 0;
      msg_sum    = OC_ZERO;
      msg_broken = 1'b0;
   endtask

   task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
      error_count++;
      $display("time %0t: %s mismatch, expected %h, got %h", $time, what, want, got);
   endtask

   task automatic absorb_word(input req_type w);
      int unsigned cnt, nwords, nb, p, i, row;
      logic [2:0]  code;
      logic [15:0] ck_sum, ck;
      logic [7:0]  b;
      rsp_type     r;
      cnt = (w.byte_count > WORD_BYTES) ? WORD_BYTES : w.byte_count;
      if (!w.last && cnt != WORD_BYTES) begin
         msg_broken = 1'b1;
      end
      if (!msg_broken) begin
         if (msg_len + cnt > MAX_PACKET_BYTES) begin
            msg_broken = 1'b1;
         end else if (cnt > 0) begin
            msg_mem[msg_len / WORD_BYTES] = w.packet_word;
            for (i = 0; i < cnt; i++) begin
               msg_sum = ones_add(msg_sum, weighted(msg_len + i, w.packet_word[WORD_W-1-8*i -: 8]));
            end
            msg_len += cnt;
         end
      end
      if (!w.last) begin
         return;
      end

      if (msg_broken) code = STATUS_BAD_LEN;
      else if (msg_len < 4) code = STATUS_SHORT;
      else if (msg_byte(0) != ICMP_ECHO_REQUEST) code = STATUS_NOT_ECHO;
      else if (msg_len < 8) code = STATUS_SHORT;
      else if (msg_len % 2 != 0) code = STATUS_BAD_LEN;
      else if (msg_sum != OC_ZERO) code = STATUS_BAD_SUM;
      else if (reply_limit == 0 || reply_limit < msg_len) code = STATUS_NO_ROOM;
      else code = STATUS_REPLY;

      if (code != STATUS_REPLY) begin
         r = '0;
         r.reply_last = 1'b1;
         r.status = code;
         reply_queue.push_back(r);
      end else begin
         // The reply checksum covers everything after the type, code and checksum bytes.
         ck_sum = OC_ZERO;
         for (i = 4; i < msg_len; i++) begin
            ck_sum = ones_add(ck_sum, weighted(i, msg_byte(i)));
         end
         ck = ~ck_sum;
         nwords = (msg_len + 7) / 8;
         for (row = 0; row < nwords; row++) begin
            r = '0;
            nb = msg_len - 8 * row;
            if (nb > 8) begin
               nb = 8;
            end
            for (i = 0; i < nb; i++) begin
               p = 8 * row + i;
               if (p < 2) b = 8'h00;
               else if (p == 2) b = ck[15:8];
               else if (p == 3) b = ck[7:0];
               else b = msg_byte(p);
               r.reply_word[WORD_W-1-8*i -: 8] = b;
            end
            r.reply_bytes  = CNT_W'(nb);
            r.reply_last   = (row == nwords - 1);
            r.dest_address = w.source_address;
            r.status       = STATUS_REPLY;
            reply_queue.push_back(r);
         end
      end
      clear_message();
   endtask

   // Results are checked before the word taken at the same edge is absorbed,
   // since a result on the bus always belongs to an earlier packet.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_message();
         reply_limit = '0;
         reply_queue.delete();
         error_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (reply_queue.size() == 0) begin
               error_count++;
               $display("time %0t: unexpected result, expected none, got %h", $time, rsp_data);
            end else begin
               want = reply_queue.pop_front();
               if (rsp_data.reply_word !== want.reply_word)
                  flag("reply_word", want.reply_word, rsp_data.reply_word);
               if (rsp_data.reply_bytes !== want.reply_bytes)
                  flag("reply_bytes", want.reply_bytes, rsp_data.reply_bytes);
               if (rsp_data.reply_last !== want.reply_last)
                  flag("reply_last", want.reply_last, rsp_data.reply_last);
               if (rsp_data.dest_address !== want.dest_address)
                  flag("dest_address", want.dest_address, rsp_data.dest_address);
               if (rsp_data.status !== want.status)
                  flag("status", want.status, rsp_data.status);
            end
         end
         if (csr_wr_en) begin
            reply_limit = csr_wr_data;
         end
         if (start && !busy) begin
            absorb_word(req_data);
         end
      end
      words_pending = reply_queue.size();
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import icmp_pkg::*;

   localparam int         CYCLE_LIMIT     = 200000;
   localparam int         SETTLE_CYCLES   = 16;
   localparam int         PHASE_WORDS     = 85;
   localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               start       = 1'b0;
   logic               busy;
   req_type            req_data    = '0;
   logic               rsp_strobe;
   rsp_type            rsp_data;
   logic               csr_wr_en   = 1'b0;
   logic [LIMIT_W-1:0] csr_wr_data = '0;

   int         error_count;
   int         words_pending;
   int         cycle_count = 0;
   int         idle_pct    = 0;
   int         words_sent  = 0;
   logic [7:0] msg_bytes [$];

   icmp_echo_responder uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   icmp_echo_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .error_count   (error_count),
      .words_pending (words_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL icmp_echo_responder");
         $finish;
      end
   end

   function automatic req_type random_word();
      req_type w;
      w.packet_word    = {$urandom, $urandom};
      w.byte_count     = CNT_W'($urandom);
      w.last           = 1'($urandom);
      w.source_address = $urandom;
      return w;
   endfunction

   // Offers one word and returns at the edge where it is taken.
   task automatic send_word(input req_type w);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start    <= 1'b0;
         req_data <= random_word();
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= w;
      do begin
         @(posedge clock);
      end while (busy);
      words_sent++;
   endtask

   // Fills msg_bytes with a message of the given type and a checksum that
   // verifies, then optionally spoils one bit after the type byte.
   task automatic make_message(input int len, input logic [7:0] kind, input bit good_sum);
      logic [31:0] acc;
      logic [15:0] ck;
      int          i;
      msg_bytes.delete();
      for (i = 0; i < len; i++) begin
         msg_bytes.push_back(8'($urandom));
      end
      if (len > 0) msg_bytes[0] = kind;
      if (len > 1) msg_bytes[1] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00;
      if (len > 3) begin
         msg_bytes[2] = 8'h00;
         msg_bytes[3] = 8'h00;
         acc = 0;
         for (i = 0; i < len; i += 2) begin
            acc += {msg_bytes[i], (i + 1 < len) ? msg_bytes[i+1] : 8'h00};
         end
         while (acc[31:16] != 0) begin
            acc = acc[15:0] + acc[31:16];
         end
         ck = ~acc[15:0];
         msg_bytes[2] = ck[15:8];
         msg_bytes[3] = ck[7:0];
         if (!good_sum) begin
            i = $urandom_range(len - 1, 1);
            msg_bytes[i] = msg_bytes[i] ^ 8'(1 << $urandom_range(7));
         end
      end
   endtask

   // Splits msg_bytes into words. Unused low bytes carry junk, and the source
   // address is only meaningful on the last word.
   task automatic send_bytes(input logic [31:0] src, input bit tail_zero, input bit wide_last,
                             input int short_at);
      int      len, nw, k, i, cnt;
      bit      zero_tail;
      req_type w;
      len       = msg_bytes.size();
      zero_tail = tail_zero || (len == 0);
      nw        = (len + 7) / 8;
      for (k = 0; k < nw; k++) begin
         w   = random_word();
         cnt = (len - 8 * k > 8) ? 8 : len - 8 * k;
         for (i = 0; i < cnt; i++) begin
            w.packet_word[WORD_W-1-8*i -: 8] = msg_bytes[8*k+i];
         end
         w.last       = (k == nw - 1) && !zero_tail;
         w.byte_count = CNT_W'(cnt);
         if (w.last && wide_last && cnt == 8) w.byte_count = CNT_W'($urandom_range(15, 9));
         if (k == short_at && !w.last) w.byte_count = CNT_W'($urandom_range(7));
         if (w.last) w.source_address = src;
         send_word(w);
      end
      if (zero_tail) begin
         w                = random_word();
         w.byte_count     = '0;
         w.last           = 1'b1;
         w.source_address = src;
         send_word(w);
      end
   endtask

   task automatic send_random_packet();
      int         pick, len, sa;
      bit         tz, wl;
      logic [7:0] kind;
      pick = $urandom_range(99);
      len  = ($urandom_range(99) < 3) ? $urandom_range(512, 49) : $urandom_range(48, 8);
      tz   = ($urandom_range(9) == 0);
      wl   = ($urandom_range(4) == 0);
      sa   = -1;
      kind = 8'($urandom);
      if (kind == ICMP_ECHO_REQUEST) kind = ICMP_ECHO_REPLY;
      if (pick < 62) begin
         make_message(len & ~1, ICMP_ECHO_REQUEST, 1'b1);
      end else if (pick < 68) begin
         make_message(len & ~1, ICMP_ECHO_REQUEST, 1'b0);
      end else if (pick < 74) begin
         make_message(len, kind, 1'b1);
      end else if (pick < 80) begin
         make_message(len | 1, ICMP_ECHO_REQUEST, 1'b1);
      end else if (pick < 86) begin
         make_message($urandom_range(7), $urandom_range(1) ? ICMP_ECHO_REQUEST : kind, 1'b1);
      end else if (pick < 93) begin
         // A short word ahead of the last one poisons the whole packet.
         if (len < 16) len = 16;
         make_message(len & ~1, ICMP_ECHO_REQUEST, 1'b1);
         sa = $urandom_range((len + 7) / 8 - 2);
      end else begin
         make_message($urandom_range(40), $urandom_range(1) ? ICMP_ECHO_REQUEST : kind,
                      1'($urandom));
      end
      send_bytes($urandom, tz, wl, sa);
   endtask

   // Waits until every expected result is out and the block has settled.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (words_pending != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_limit(input int value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= LIMIT_W'(value);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_phase(input int pct, input int value, input int special);
      int target;
      set_limit(value);
      idle_pct = pct;
      target   = words_sent + PHASE_WORDS;
      if (special == 1) begin
         make_message($urandom_range(540, 513), ICMP_ECHO_REQUEST, 1'b1);
         send_bytes($urandom, 1'b0, 1'b0, -1);
      end else if (special == 2) begin
         make_message(MAX_PACKET_BYTES, ICMP_ECHO_REQUEST, 1'b1);
         send_bytes($urandom, 1'b0, 1'b0, -1);
      end
      while (words_sent < target) begin
         send_random_packet();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed cases, first with replies disabled.
      set_limit(0);
      make_message(8, ICMP_ECHO_REQUEST, 1'b1);
      send_bytes($urandom, 1'b0, 1'b0, -1);
      set_limit(MAX_PACKET_BYTES);
      make_message(8, ICMP_ECHO_REQUEST, 1'b1);
      send_bytes(32'h0000_0000, 1'b0, 1'b1, -1);
      make_message(16, ICMP_ECHO_REQUEST, 1'b1);
      send_bytes(32'hffff_ffff, 1'b1, 1'b0, -1);
      make_message(3, ICMP_ECHO_REQUEST, 1'b1);
      send_bytes($urandom, 1'b0, 1'b0, -1);
      make_message(0, ICMP_ECHO_REQUEST, 1'b1);
      send_bytes($urandom, 1'b0, 1'b0, -1);
      make_message(8, ICMP_ECHO_REPLY, 1'b1);
      send_bytes($urandom, 1'b0, 1'b0, -1);
      make_message(8, 8'hff, 1'b1);
      send_bytes($urandom, 1'b0, 1'b0, -1);
      make_message(5, ICMP_ECHO_REQUEST, 1'b1);
      send_bytes($urandom, 1'b0, 1'b0, -1);
      make_message(4, ICMP_ECHO_REQUEST, 1'b1);
      send_bytes($urandom, 1'b0, 1'b0, -1);
      make_message(9, ICMP_ECHO_REQUEST, 1'b1);
      send_bytes($urandom, 1'b0, 1'b0, -1);
      make_message(8, ICMP_ECHO_REQUEST, 1'b0);
      send_bytes($urandom, 1'b0, 1'b0, -1);
      make_message(24, ICMP_ECHO_REQUEST, 1'b1);
      send_bytes($urandom, 1'b0, 1'b0, 0);
      make_message(22, ICMP_ECHO_REQUEST, 1'b1);
      send_bytes($urandom, 1'b0, 1'b0, -1);

      run_phase(0, MAX_PACKET_BYTES, 1);
      run_phase(79, 2 * $urandom_range(32, 4), 0);
      run_phase(0, $urandom_range(511, 65), 0);
      run_phase(8, (1 << LIMIT_W) - 1, 2);

      drain();
      if (error_count == 0) begin
         $display("PASS icmp_echo_responder");
      end else begin
         $display("FAIL icmp_echo_responder");
      end
      $finish;
   end

endmodule
